// File: design/tbpr_pkg.sv
// ----------------------------------------------------------------------------
// tbpr_pkg
// Shared types, constants and helpers for the tile background pixel renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpr_pkg;

    // video memory geometry
    localparam int VRAM_BYTES     = 8192;
    localparam int VRAM_AW        = $clog2(VRAM_BYTES);
    localparam int BANK_BYTES     = VRAM_BYTES / 2;
    localparam int BANK_AW        = $clog2(BANK_BYTES);

    // item kinds
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // window column offset
    localparam logic [7:0] WINDOW_SHIFT = 8'd7;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DISPLAY_CTRL = 3'd0,
        CFG_SCROLL_Y     = 3'd1,
        CFG_SCROLL_X     = 3'd2,
        CFG_WINDOW_Y     = 3'd3,
        CFG_WINDOW_COL   = 3'd4,
        CFG_BG_PALETTE   = 3'd5
    } cfg_index_t;

    // reset values of the configuration registers
    localparam logic [7:0] DISPLAY_CTRL_RST = 8'd145;
    localparam logic [7:0] BG_PALETTE_RST   = 8'd252;

    // display_ctrl bit positions
    localparam int LCDC_BG_ON      = 0;
    localparam int LCDC_BG_MAP     = 3;
    localparam int LCDC_UNSIGNED   = 4;
    localparam int LCDC_WIN_ON     = 5;
    localparam int LCDC_WIN_MAP    = 6;

    // grey level for each shade, packed red, green, blue, alpha
    function automatic logic [31:0] grey_rgba(input logic [1:0] shade);
        logic [31:0] rgba;
        case (shade)
            2'd0:    rgba = 32'hFFFF_FFFF;
            2'd1:    rgba = 32'hA9A9_A9FF;
            2'd2:    rgba = 32'h5454_54FF;
            default: rgba = 32'h0000_00FF;
        endcase
        return rgba;
    endfunction

endpackage

`default_nettype wire

// File: design/tile_background_pixel_renderer_top.sv
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer_top
// Tile-map background and window pixel renderer with its own video memory.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_ready is high: a write item
// stores a byte into the 8 KiB video memory and gives no result, a render item
// gives one pixel result through the stage 1, stage 2 and output registers.
// The pixel path is a three-stage pipeline around two dependent memory reads:
// the tile-map entry is read from a full copy of video memory, then the two
// bit-plane bytes of the tile line are read in the same cycle from an even-byte
// bank and an odd-byte bank. Every write item goes to the full copy and to one
// bank. After reset the block sweeps all 8192 addresses to zero, one per cycle,
// and holds in_ready low until the sweep is done; configuration writes are
// taken at any time and are expected only while no render item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_background_pixel_renderer_top
    import tbpr_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 160
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,

    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [12:0] vram_address,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  pixel_x,
    input  wire logic [7:0]  line,

    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_x,
    output logic [7:0]       out_line,
    output logic             drawn,
    output logic [1:0]       palette_index,
    output logic [1:0]       shade,
    output logic [31:0]      color_rgba
);

    // configuration registers
    logic [7:0] display_ctrl_reg;
    logic [7:0] scroll_y_reg;
    logic [7:0] scroll_x_reg;
    logic [7:0] window_y_reg;
    logic [7:0] window_col_reg;
    logic [7:0] bg_palette_reg;

    // clearing sweep
    logic               clr_active_reg;
    logic [VRAM_AW-1:0] clr_addr_reg;
    logic [VRAM_AW-1:0] clr_addr_next;

    // pipeline control
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic in_acc;
    logic render_acc;
    logic wr_acc;

    // stage 0 address generation
    logic [7:0]         win_start;
    logic               use_window;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic               map_sel;
    logic [VRAM_AW-1:0] map_addr;
    logic               pix_on;

    // stage 1: map entry arrives
    logic       s1_valid_reg;
    logic [7:0] s1_x_reg;
    logic [7:0] s1_line_reg;
    logic       s1_drawn_reg;
    logic [2:0] s1_fine_x_reg;
    logic [2:0] s1_fine_y_reg;
    logic [7:0] map_entry;
    logic       tile_hi_bit;
    logic [BANK_AW-1:0] tile_row_addr;

    // stage 2: bit-plane bytes arrive
    logic       s2_valid_reg;
    logic [7:0] s2_x_reg;
    logic [7:0] s2_line_reg;
    logic       s2_drawn_reg;
    logic [2:0] s2_fine_x_reg;
    logic [7:0] plane_lo;
    logic [7:0] plane_hi;
    logic [2:0] bit_sel;
    logic [1:0] ci;
    logic [7:0] pal_shifted;
    logic [1:0] sh;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_x_reg;
    logic [7:0]  out_line_reg;
    logic        drawn_reg;
    logic [1:0]  palette_index_reg;
    logic [1:0]  shade_reg;
    logic [31:0] color_rgba_reg;

    // memory ports
    logic               full_we;
    logic [VRAM_AW-1:0] full_waddr;
    logic [7:0]         wdata_mux;
    logic               even_we;
    logic               odd_we;
    logic [BANK_AW-1:0] bank_waddr;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_ctrl_reg <= DISPLAY_CTRL_RST;
            scroll_y_reg     <= 8'd0;
            scroll_x_reg     <= 8'd0;
            window_y_reg     <= 8'd0;
            window_col_reg   <= 8'd0;
            bg_palette_reg   <= BG_PALETTE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_CTRL: display_ctrl_reg <= cfg_data;
                CFG_SCROLL_Y:     scroll_y_reg     <= cfg_data;
                CFG_SCROLL_X:     scroll_x_reg     <= cfg_data;
                CFG_WINDOW_Y:     window_y_reg     <= cfg_data;
                CFG_WINDOW_COL:   window_col_reg   <= cfg_data;
                CFG_BG_PALETTE:   bg_palette_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // zero sweep of video memory after reset
    assign clr_addr_next = clr_addr_reg + VRAM_AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_next;
            if (clr_addr_reg == {VRAM_AW{1'b1}})
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // stage enables: each stage moves when the one after it has room
    assign out_en     = !out_valid_reg || out_ready;
    assign s2_en      = !s2_valid_reg || out_en;
    assign s1_en      = !s1_valid_reg || s2_en;
    assign in_ready   = s1_en && !clr_active_reg;
    assign in_acc     = in_valid && in_ready;
    assign render_acc = in_acc && (mode == MODE_RENDER);
    assign wr_acc     = in_acc && (mode == MODE_WRITE);

    // window or scrolled background, map entry address
    always_comb
    begin
        win_start  = window_col_reg - WINDOW_SHIFT;
        use_window = display_ctrl_reg[LCDC_WIN_ON] && (window_y_reg <= line)
                     && (pixel_x >= win_start);
        if (use_window)
        begin
            pos_x   = pixel_x - win_start;
            pos_y   = line - window_y_reg;
            map_sel = display_ctrl_reg[LCDC_WIN_MAP];
        end
        else
        begin
            pos_x   = pixel_x + scroll_x_reg;
            pos_y   = line + scroll_y_reg;
            map_sel = display_ctrl_reg[LCDC_BG_MAP];
        end
        // maps sit at 0x1800 and 0x1C00, 32 entries a row
        map_addr = {2'b11, map_sel, pos_y[7:3], pos_x[7:3]};
        pix_on   = display_ctrl_reg[LCDC_BG_ON]
                   && ({1'b0, pixel_x} < 9'(SCREEN_COLUMNS));
    end

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= render_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_x_reg      <= pixel_x;
            s1_line_reg   <= line;
            s1_drawn_reg  <= pix_on;
            s1_fine_x_reg <= pos_x[2:0];
            s1_fine_y_reg <= pos_y[2:0];
        end
    end

    // tile line address: signed numbering puts tiles 0..127 at 0x1000
    always_comb
    begin
        tile_hi_bit   = !display_ctrl_reg[LCDC_UNSIGNED] && !map_entry[7];
        // even byte is the low plane, odd byte the high plane
        tile_row_addr = {tile_hi_bit, map_entry, s1_fine_y_reg};
    end

    // stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_x_reg      <= s1_x_reg;
            s2_line_reg   <= s1_line_reg;
            s2_drawn_reg  <= s1_drawn_reg;
            s2_fine_x_reg <= s1_fine_x_reg;
        end
    end

    // colour index and palette lookup
    always_comb
    begin
        bit_sel     = ~s2_fine_x_reg;
        ci          = {plane_hi[bit_sel], plane_lo[bit_sel]};
        pal_shifted = bg_palette_reg >> {ci, 1'b0};
        sh          = pal_shifted[1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_x_reg    <= s2_x_reg;
            out_line_reg <= s2_line_reg;
            drawn_reg    <= s2_drawn_reg;
            if (s2_drawn_reg)
            begin
                palette_index_reg <= ci;
                shade_reg         <= sh;
                color_rgba_reg    <= grey_rgba(sh);
            end
            else
            begin
                palette_index_reg <= 2'd0;
                shade_reg         <= 2'd0;
                color_rgba_reg    <= 32'd0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_x_reg;
    assign out_line      = out_line_reg;
    assign drawn         = drawn_reg;
    assign palette_index = palette_index_reg;
    assign shade         = shade_reg;
    assign color_rgba    = color_rgba_reg;

    // write muxing: sweep or write item
    assign full_we    = clr_active_reg || wr_acc;
    assign full_waddr = clr_active_reg ? clr_addr_reg : vram_address;
    assign wdata_mux  = clr_active_reg ? 8'd0 : write_data;
    assign bank_waddr = clr_active_reg ? clr_addr_reg[VRAM_AW-1:1]
                                       : vram_address[VRAM_AW-1:1];
    assign even_we    = clr_active_reg || (wr_acc && !vram_address[0]);
    assign odd_we     = clr_active_reg || (wr_acc && vram_address[0]);

    // full copy, read for tile-map entries
    tbpr_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_BYTES)
    ) u_map_ram (
        .clk   (clk),
        .we    (full_we),
        .waddr (full_waddr),
        .wdata (wdata_mux),
        .re    (s1_en),
        .raddr (map_addr),
        .rdata (map_entry)
    );

    // even bytes, low bit plane
    tbpr_ram #(
        .WIDTH (8),
        .DEPTH (BANK_BYTES)
    ) u_even_ram (
        .clk   (clk),
        .we    (even_we),
        .waddr (bank_waddr),
        .wdata (wdata_mux),
        .re    (s2_en),
        .raddr (tile_row_addr),
        .rdata (plane_lo)
    );

    // odd bytes, high bit plane
    tbpr_ram #(
        .WIDTH (8),
        .DEPTH (BANK_BYTES)
    ) u_odd_ram (
        .clk   (clk),
        .we    (odd_we),
        .waddr (bank_waddr),
        .wdata (wdata_mux),
        .re    (s2_en),
        .raddr (tile_row_addr),
        .rdata (plane_hi)
    );

endmodule

`default_nettype wire

// File: design/tbpr_ram.sv
// ----------------------------------------------------------------------------
// tbpr_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
